// ----- design/integer_literal_parser_defines.svh -----
// Assertion macros for the verification file of the literal parser.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ILP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define ILP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ilp_pkg.sv -----
// Shared types and constants of the integer literal parser.
// No dependencies; used by every module of the block.
package ilp_pkg;

  localparam int VALUE_WIDTH = 32;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Characters that steer the parse.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;

  // Offsets that turn a hex letter into its digit value.
  localparam logic [7:0] HEX_LO_BIAS = 8'd87;
  localparam logic [7:0] HEX_UP_BIAS = 8'd55;

  typedef enum logic [1:0] {
    PH_START       = 2'd0,
    PH_AFTER_MINUS = 2'd1,
    PH_AFTER_ZERO  = 2'd2,
    PH_DIGITS      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2,
    RADIX_BIN = 2'd3
  } radix_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_literal;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [1:0]                    radix_code;
  } out_beat_t;

  typedef struct packed {
    phase_t phase;
    logic   negative_flag;
    logic   octal_flag;
    logic   hex_flag;
    value_t main_accumulator;
    value_t binary_accumulator;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:              PH_START,
    negative_flag:      1'b0,
    octal_flag:         1'b0,
    hex_flag:           1'b0,
    main_accumulator:   '0,
    binary_accumulator: '0
  };

  typedef struct packed {
    logic      has_result;
    out_beat_t beat;
  } step_out_t;

endpackage

// ----- design/ilp_step.sv -----
// Per-character step of the literal parser: prefix decode, digit accumulate, result.
// Combinational; uses types and constants from ilp_pkg.
module ilp_step (
  input  ilp_pkg::parse_state_t state,
  input  ilp_pkg::in_beat_t     beat,
  output ilp_pkg::parse_state_t state_next,
  output ilp_pkg::step_out_t    result
);

  ilp_pkg::parse_state_t upd;
  ilp_pkg::value_t       sym_wide;
  ilp_pkg::value_t       dec_digit;
  ilp_pkg::value_t       hex_digit;
  ilp_pkg::value_t       main_scaled;
  ilp_pkg::value_t       main_sum;
  ilp_pkg::value_t       bin_sum;
  ilp_pkg::value_t       chosen;
  ilp_pkg::value_t       signed_res;
  logic                  consumed;
  logic                  suffix_b;
  logic [1:0]            code;

  assign sym_wide  = ilp_pkg::value_t'(beat.symbol);
  assign dec_digit = sym_wide - ilp_pkg::value_t'(ilp_pkg::CH_ZERO);

  always_comb begin
    if (beat.symbol >= ilp_pkg::CH_ZERO && beat.symbol <= ilp_pkg::CH_NINE) begin
      hex_digit = dec_digit;
    end else if (beat.symbol >= ilp_pkg::CH_A_LO && beat.symbol <= ilp_pkg::CH_Z_LO) begin
      hex_digit = sym_wide - ilp_pkg::value_t'(ilp_pkg::HEX_LO_BIAS);
    end else begin
      hex_digit = sym_wide - ilp_pkg::value_t'(ilp_pkg::HEX_UP_BIAS);
    end
  end

  // Prefix handling: each phase may swallow the character or hand it on.
  always_comb begin
    upd      = state;
    consumed = 1'b0;
    if (upd.phase == ilp_pkg::PH_START) begin
      upd.phase = ilp_pkg::PH_AFTER_MINUS;
      if (beat.symbol == ilp_pkg::CH_MINUS) begin
        upd.negative_flag = 1'b1;
        consumed          = 1'b1;
      end
    end
    if (!consumed && upd.phase == ilp_pkg::PH_AFTER_MINUS) begin
      upd.phase = ilp_pkg::PH_DIGITS;
      if (beat.symbol == ilp_pkg::CH_ZERO) begin
        upd.octal_flag = 1'b1;
        upd.phase      = ilp_pkg::PH_AFTER_ZERO;
        consumed       = 1'b1;
      end
    end
    if (!consumed && upd.phase == ilp_pkg::PH_AFTER_ZERO) begin
      upd.phase = ilp_pkg::PH_DIGITS;
      if (beat.symbol == ilp_pkg::CH_X_LO || beat.symbol == ilp_pkg::CH_X_UP) begin
        upd.hex_flag = 1'b1;
        consumed     = 1'b1;
      end
    end
  end

  // Radix multiply as shifts: 16, 8 or 8 + 2.
  always_comb begin
    if (upd.hex_flag) begin
      main_scaled = state.main_accumulator << 4;
    end else if (upd.octal_flag) begin
      main_scaled = state.main_accumulator << 3;
    end else begin
      main_scaled = (state.main_accumulator << 3) + (state.main_accumulator << 1);
    end
  end

  assign main_sum = main_scaled + (upd.hex_flag ? hex_digit : dec_digit);
  assign bin_sum  = (state.binary_accumulator << 1) + dec_digit;
  assign suffix_b = !consumed && beat.end_of_literal && beat.symbol == ilp_pkg::CH_B_LO &&
                    !upd.hex_flag;

  always_comb begin
    state_next = upd;
    if (!consumed && !suffix_b) begin
      state_next.main_accumulator   = main_sum;
      state_next.binary_accumulator = bin_sum;
    end
    if (suffix_b) begin
      chosen = state.binary_accumulator;
      code   = ilp_pkg::RADIX_BIN;
    end else begin
      chosen = state_next.main_accumulator;
      if (upd.hex_flag) begin
        code = ilp_pkg::RADIX_HEX;
      end else if (upd.octal_flag) begin
        code = ilp_pkg::RADIX_OCT;
      end else begin
        code = ilp_pkg::RADIX_DEC;
      end
    end
    // A finished literal leaves the parser ready for the next one.
    if (beat.end_of_literal) begin
      state_next = ilp_pkg::STATE_RESET;
    end
  end

  assign signed_res             = upd.negative_flag ? (ilp_pkg::value_t'(0) - chosen) : chosen;
  assign result.has_result      = beat.end_of_literal;
  assign result.beat.value      = $signed(signed_res);
  assign result.beat.radix_code = code;

endmodule

// ----- design/integer_literal_parser.sv -----
// Integer literal parser, top level: input register, parse state, result register.
// Depends on ilp_pkg and ilp_step.
//
// Usage: characters of a numeric literal arrive one per beat on the lit channel
// (lit_beat.symbol), with lit_beat.end_of_literal set on the last character.
// For each literal one beat leaves on the res channel carrying the 32-bit value
// and the radix code (decimal, octal, hex or binary).
// Throughput is one character per cycle while the result register is not held by
// res_stall. The parse state is updated by one shift-add step per character,
// between the input register and the result register.
// A final character passes the input register and then the result register
// before its result beat can be taken.
// When res_stall holds a full result register, the input register stops as
// well; once it holds a character, lit_stall rises until the result beat is taken.
// Reset (rst, synchronous) empties both registers and returns the parse state
// to the start of a literal.
module integer_literal_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 lit_valid,
  output logic                 lit_stall,
  input  ilp_pkg::in_beat_t    lit_beat,
  output logic                 res_valid,
  input  logic                 res_stall,
  output ilp_pkg::out_beat_t   res_beat
);

  logic                  in_full;
  ilp_pkg::in_beat_t     in_data;
  ilp_pkg::parse_state_t state;
  ilp_pkg::parse_state_t state_next;
  ilp_pkg::step_out_t    step_res;
  logic                  advance;

  ilp_step u_step (
    .state      (state),
    .beat       (in_data),
    .state_next (state_next),
    .result     (step_res)
  );

  assign advance   = in_full && (!res_valid || !res_stall);
  assign lit_stall = in_full && res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (lit_valid && !lit_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lit_valid && !lit_stall) begin
      in_data <= lit_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilp_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step_res.has_result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.has_result) begin
      res_beat <= step_res.beat;
    end
  end

endmodule

// ----- design/ilp_checker.sv -----
// Port-level checks of the integer literal parser, bound to its top level.
// Depends on ilp_pkg and integer_literal_parser_defines.svh.
`include "integer_literal_parser_defines.svh"

module ilp_checker (
  input logic               clk,
  input logic               rst,
  input logic               lit_valid,
  input logic               lit_stall,
  input ilp_pkg::in_beat_t  lit_beat,
  input logic               res_valid,
  input logic               res_stall,
  input ilp_pkg::out_beat_t res_beat
);

  logic lit_take;
  logic res_take;

  assign lit_take = lit_valid && !lit_stall;
  assign res_take = res_valid && !res_stall;

  // A held result beat keeps its value.
  `ILP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_beat),
                   "result beat changed while stalled")

  // A held character beat keeps its value.
  `ILP_ASSERT_NEXT(a_lit_hold, lit_valid && lit_stall, lit_valid && $stable(lit_beat),
                   "character beat changed while stalled")

  // Input backpressure only comes from a stalled, full result register.
  `ILP_ASSERT_NOW(a_stall_cause, lit_stall, res_valid && res_stall,
                  "input stalled without output stall")

  // With no character taken, and then none taken while the output is empty, no result can appear.
  `ILP_ASSERT_NEXT(a_no_phantom, (!lit_take) ##1 (!lit_take && !res_valid), !res_valid,
                   "result beat without a literal")

  // A beat that is taken leaves the register empty when no character was waiting.
  `ILP_ASSERT_NEXT(a_no_repeat, res_take && !lit_take && !$past(lit_take || lit_stall),
                   !res_valid, "result beat repeated")

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (.*);
